[rtl/motion_to_arrow_pulse_shaper_core_assert.svh]
// Assertion macros used by the pulse shaper checker.
`ifndef MOTION_TO_ARROW_PULSE_SHAPER_CORE_ASSERT_SVH
`define MOTION_TO_ARROW_PULSE_SHAPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define MAPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pulse shaper check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define MAPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pulse shaper check failed");

`endif

[rtl/maps_pkg.sv]
// Shared constants, register indexes and control structs of the pulse shaper.
package maps_pkg;

  localparam int unsigned DeltaW     = 8;
  localparam int unsigned MagW       = 8;
  localparam int unsigned DeadW      = 7;
  localparam int unsigned DivW       = 12;
  localparam int unsigned ResW       = 16;
  localparam int unsigned FullScale  = 128;
  localparam int unsigned FullSq     = FullScale * FullScale;
  localparam int unsigned SqW        = $clog2(FullSq) + 1;
  localparam int unsigned SqShift    = $clog2(FullSq);
  localparam int unsigned ProdW      = DivW + SqW;
  localparam int unsigned DivSteps   = ResW;
  localparam int unsigned CntW       = $clog2(DivSteps);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned InTdataW   = 8;
  localparam int unsigned OutTdataW  = 8;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgDeadBand = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSlowDiv  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFastDiv  = 2'd2;

  // Register reset values
  localparam logic [DeadW-1:0] DeadRst = 7'd0;
  localparam logic [DivW-1:0]  SlowRst = 12'd64;
  localparam logic [DivW-1:0]  FastRst = 12'd8;

  // Pulse direction codes
  localparam logic [1:0] DirNone = 2'b00;
  localparam logic [1:0] DirPos  = 2'b01;
  localparam logic [1:0] DirNeg  = 2'b11;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture input beat
    logic square;    // mag^2 and dead band compare
    logic mul;       // curve products and residue sum
    logic curve;     // divisor and divider setup
    logic div_step;  // one restoring divide step
    logic finish;    // write result, update residue
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip;      // delta inside the dead band
    logic div_last;  // this is the final divide step
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

[rtl/motion_to_arrow_pulse_shaper_core.sv]
// Top level of the motion-to-arrow pulse shaper.
// One sample is taken at a time. A sample outside the dead band goes from acceptance
// to the next ready through accept, square, the two curve products and the divisor,
// the one-bit-per-cycle restoring divider that yields the residue remainder, and the
// result write; a sample inside the dead band skips the products, divisor and divide.
// The result sits in an output register, so the next sample is taken while it waits.
// tdata bits: in [7:0] motion_delta; out [0] pulse_fire, [2:1] pulse_direction.
module motion_to_arrow_pulse_shaper_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [maps_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [maps_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [maps_pkg::InTdataW-1:0]         s_axis_tdata,   // [7:0] motion_delta
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [maps_pkg::OutTdataW-1:0]        m_axis_tdata    // [0] pulse_fire,
                                                                // [2:1] pulse_direction
);

  maps_pkg::cmd_t cmd;
  maps_pkg::sts_t sts;
  logic           out_fire;
  logic [1:0]     out_dir;

  maps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  maps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .delta_i     (s_axis_tdata[maps_pkg::DeltaW-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_fire_o  (out_fire),
    .out_dir_o   (out_dir)
  );

  assign m_axis_tdata = {5'b00000, out_dir, out_fire};

endmodule

[rtl/maps_ctrl.sv]
// Sequencer for one sample: square, multiply, divisor, serial divide, finish.
module maps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  maps_pkg::sts_t  sts_i,
  output maps_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StMul,
    StCurve,
    StDiv,
    StFinish
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSquare;
        end
      end
      StSquare: begin
        cmd_o.square = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        if (sts_i.skip) begin
          state_d = StFinish;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = StCurve;
        end
      end
      StCurve: begin
        cmd_o.curve = 1'b1;
        state_d     = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/maps_datapath.sv]
// Config registers, residue, divisor curve, serial divider and output register.
module maps_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [maps_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [maps_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic signed [maps_pkg::DeltaW-1:0]   delta_i,
  input  maps_pkg::cmd_t                       cmd_i,
  output maps_pkg::sts_t                       sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 out_fire_o,
  output logic [1:0]                           out_dir_o
);

  // Config registers
  logic [maps_pkg::DeadW-1:0] dead_q;
  logic [maps_pkg::DivW-1:0]  slow_q, fast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q <= maps_pkg::DeadRst;
      slow_q <= maps_pkg::SlowRst;
      fast_q <= maps_pkg::FastRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        maps_pkg::CfgDeadBand: dead_q <= cfg_data_i[maps_pkg::DeadW-1:0];
        maps_pkg::CfgSlowDiv:  slow_q <= cfg_data_i[maps_pkg::DivW-1:0];
        maps_pkg::CfgFastDiv:  fast_q <= cfg_data_i[maps_pkg::DivW-1:0];
        default: ;
      endcase
    end
  end

  // Working registers for one sample
  logic signed [maps_pkg::DeltaW-1:0] delta_q;
  logic [maps_pkg::MagW-1:0]          mag_q;
  logic [maps_pkg::SqW-1:0]           sq_q;
  logic                               skip_q;
  logic [maps_pkg::ProdW-1:0]         p_slow_q, p_fast_q;
  logic [maps_pkg::DivW-1:0]          div_q;
  logic                               neg_q;
  logic [maps_pkg::ResW-1:0]          dvd_q;
  logic [maps_pkg::DivW-1:0]          rem_q;
  logic [maps_pkg::CntW-1:0]          cnt_q;
  logic                               fire_q;
  logic signed [maps_pkg::ResW-1:0]   residue_q;

  logic [2*maps_pkg::MagW-1:0]        sq_full;
  logic [maps_pkg::SqW-1:0]           sq_rest;
  logic signed [maps_pkg::ResW-1:0]   sum_r;
  logic [maps_pkg::ProdW-1:0]         num;
  logic [maps_pkg::ProdW-maps_pkg::SqShift-1:0] quo;
  logic [maps_pkg::DivW:0]            trial;
  logic                               trial_ge;
  logic [maps_pkg::DivW+1:0]          rem_x3;
  logic [maps_pkg::DivW-1:0]          decayed;

  assign sq_full  = mag_q * mag_q;
  assign sq_rest  = maps_pkg::SqW'(maps_pkg::FullSq) - sq_q;
  assign sum_r    = residue_q + maps_pkg::ResW'(delta_q);
  assign num      = p_slow_q + p_fast_q;
  assign quo      = num[maps_pkg::ProdW-1:maps_pkg::SqShift];
  // Restoring step: bring down the next dividend bit
  assign trial    = {rem_q, dvd_q[maps_pkg::ResW-1]};
  assign trial_ge = trial >= {1'b0, div_q};
  // 3/4 decay on the remainder magnitude, truncating toward zero
  assign rem_x3   = {2'b00, rem_q} + {1'b0, rem_q, 1'b0};
  assign decayed  = rem_x3[maps_pkg::DivW+1:2];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delta_q <= delta_i;
      mag_q   <= delta_i[maps_pkg::DeltaW-1] ? maps_pkg::MagW'(-delta_i)
                                             : maps_pkg::MagW'(delta_i);
    end
    if (cmd_i.square) begin
      sq_q   <= sq_full[maps_pkg::SqW-1:0];
      skip_q <= mag_q <= {1'b0, dead_q};
    end
    if (cmd_i.mul) begin
      p_slow_q <= maps_pkg::ProdW'(slow_q) * maps_pkg::ProdW'(sq_rest);
      p_fast_q <= maps_pkg::ProdW'(fast_q) * maps_pkg::ProdW'(sq_q);
      neg_q    <= sum_r[maps_pkg::ResW-1];
      dvd_q    <= sum_r[maps_pkg::ResW-1] ? maps_pkg::ResW'(-sum_r)
                                          : maps_pkg::ResW'(sum_r);
    end
    if (cmd_i.curve) begin
      // A zero curve result counts as a divisor of one
      div_q  <= (quo == '0) ? maps_pkg::DivW'(1) : quo[maps_pkg::DivW-1:0];
      rem_q  <= '0;
      cnt_q  <= '0;
      fire_q <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? maps_pkg::DivW'(trial - {1'b0, div_q})
                         : trial[maps_pkg::DivW-1:0];
      dvd_q  <= {dvd_q[maps_pkg::ResW-2:0], 1'b0};
      cnt_q  <= cnt_q + 1'b1;
      fire_q <= fire_q | trial_ge;
    end
  end

  // Residue: keeps decayed remainder, untouched inside the dead band
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residue_q <= '0;
    end else if (cmd_i.finish && !skip_q) begin
      residue_q <= neg_q ? -maps_pkg::ResW'(decayed) : maps_pkg::ResW'(decayed);
    end
  end

  // Output register
  logic       out_valid_q;
  logic       out_fire_q;
  logic [1:0] out_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_fire_q <= fire_q && !skip_q;
      out_dir_q  <= (fire_q && !skip_q) ? (neg_q ? maps_pkg::DirNeg : maps_pkg::DirPos)
                                        : maps_pkg::DirNone;
    end
  end

  assign sts_o.skip     = skip_q;
  assign sts_o.div_last = cnt_q == maps_pkg::CntW'(maps_pkg::DivSteps - 1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_fire_o     = out_fire_q;
  assign out_dir_o      = out_dir_q;

endmodule

[rtl/maps_checker.sv]
// Port-level checks of the pulse shaper, bound to the top level.
`include "motion_to_arrow_pulse_shaper_core_assert.svh"

module maps_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [maps_pkg::OutTdataW-1:0] m_axis_tdata
);

  // Result fields
  logic       out_fire;
  logic [1:0] out_dir;
  logic       dir_signed;

  assign out_fire   = m_axis_tdata[0];
  assign out_dir    = m_axis_tdata[2:1];
  assign dir_signed = (out_dir == maps_pkg::DirPos) || (out_dir == maps_pkg::DirNeg);

  // No pulse means no direction
  `MAPS_ASSERT_NOW(a_idle_dir, m_axis_tvalid && !out_fire, out_dir == maps_pkg::DirNone)
  // A pulse always carries a sign
  `MAPS_ASSERT_NOW(a_fire_dir, m_axis_tvalid && out_fire, dir_signed)
  // One sample in flight: ready drops right after an accepted beat
  `MAPS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A stalled result beat holds
  `MAPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind motion_to_arrow_pulse_shaper_core maps_checker u_maps_checker (.*);
